// ----- hw/rtl/ctqs_pkg.sv -----
// shared types and constants for the cancellable ticket queue server
package ctqs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int TICKET_W    = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME     = 1'd1;

    localparam logic [TICKET_W-1:0] SERVICE_PERIOD_RST = 16'd10;
    localparam logic [TICKET_W-1:0] CLOSE_TIME_RST     = 16'hFFFF;
    localparam logic [TICKET_W-1:0] MINUTE_MAX         = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ENTER  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec_op;
        logic advance;
        logic serve;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic serve_due;
        logic queue_empty;
        logic head_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/cancellable_ticket_queue_server_unit.sv -----
// Cancellable ticket queue server: one item in, one result out. An enter or
// cancel passes through the exec and result states and back to idle before the
// next transfer. A tick does the same when no service is due; when service is
// due it passes exec, skip read, skip check and result (skip read goes straight
// to result when the queue is empty), with one more skip read and check per
// cancelled ticket the head skips, as the head walks the valid memory one slot
// per read. The output register holds a result until it is taken, but a new
// item is only taken once the previous result has entered that register. No
// clearing pass is needed after reset. Configuration writes take effect at once.
module cancellable_ticket_queue_server_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ctqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctqs_pkg::TICKET_W-1:0]   cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic [ctqs_pkg::TICKET_W-1:0]   cancel_ticket,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            served_valid,
    output logic [ctqs_pkg::TICKET_W-1:0]   served_ticket,
    output logic [ctqs_pkg::TICKET_W-1:0]   issued_ticket,
    output logic [1:0]                      status
);

    ctqs_pkg::dp_cmd_t    cmd;
    ctqs_pkg::dp_status_t stat;

    ctqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctqs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .op            (op),
        .cancel_ticket (cancel_ticket),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .served_valid  (served_valid),
        .served_ticket (served_ticket),
        .issued_ticket (issued_ticket),
        .status        (status),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// ----- hw/rtl/ctqs_ctrl.sv -----
// controller state machine: sequences one item through exec, head skip and result
module ctqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ctqs_pkg::dp_status_t stat,
    output ctqs_pkg::dp_cmd_t    cmd
);

    ctqs_pkg::state_t state_reg;
    ctqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctqs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ctqs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ctqs_pkg::S_EXEC;
                end
            end
            ctqs_pkg::S_EXEC:
            begin
                cmd.exec_op = 1'b1;
                if (stat.op == ctqs_pkg::OP_TICK && stat.serve_due)
                begin
                    state_next = ctqs_pkg::S_SKIP_RD;
                end
                else
                begin
                    state_next = ctqs_pkg::S_RESULT;
                end
            end
            ctqs_pkg::S_SKIP_RD:
            begin
                // head slot is read at this edge
                if (stat.queue_empty)
                begin
                    state_next = ctqs_pkg::S_RESULT;
                end
                else
                begin
                    state_next = ctqs_pkg::S_SKIP_CHK;
                end
            end
            ctqs_pkg::S_SKIP_CHK:
            begin
                if (stat.head_valid)
                begin
                    cmd.serve  = 1'b1;
                    state_next = ctqs_pkg::S_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ctqs_pkg::S_SKIP_RD;
                end
            end
            ctqs_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ctqs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ctqs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ctqs_datapath.sv -----
// datapath: config, counters, head/tail pointers, valid memory and output register
module ctqs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ctqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctqs_pkg::TICKET_W-1:0]   cfg_wdata,
    input  logic [1:0]                      op,
    input  logic [ctqs_pkg::TICKET_W-1:0]   cancel_ticket,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            served_valid,
    output logic [ctqs_pkg::TICKET_W-1:0]   served_ticket,
    output logic [ctqs_pkg::TICKET_W-1:0]   issued_ticket,
    output logic [1:0]                      status,
    input  ctqs_pkg::dp_cmd_t               cmd,
    output ctqs_pkg::dp_status_t            stat
);

    localparam int TW = ctqs_pkg::TICKET_W;
    localparam int SW = ctqs_pkg::SLOT_W;
    localparam logic [TW-1:0] DEPTH_T = TW'(ctqs_pkg::QUEUE_DEPTH);
    localparam logic [SW:0]   DEPTH_S = (SW+1)'(ctqs_pkg::QUEUE_DEPTH);

    ctqs_pkg::op_t    item_op_reg;
    logic [TW-1:0]    item_cancel_reg;
    logic [TW-1:0]    period_reg;
    logic [TW-1:0]    close_reg;
    logic [TW-1:0]    minute_reg;
    logic [TW-1:0]    phase_reg;
    logic [TW-1:0]    head_reg;
    logic [TW-1:0]    tail_reg;
    logic [SW-1:0]    head_slot_reg;
    logic             rd_valid_reg;

    logic             res_served_valid_reg;
    logic [TW-1:0]    res_served_ticket_reg;
    logic [TW-1:0]    res_issued_reg;
    ctqs_pkg::status_t res_status_reg;

    logic             out_valid_reg;
    logic             out_served_valid_reg;
    logic [TW-1:0]    out_served_ticket_reg;
    logic [TW-1:0]    out_issued_reg;
    logic [1:0]       out_status_reg;

    // entries outside head..tail are never used and every entry inside was
    // written by its enter, so the memory needs no clearing after reset
    logic             valid_mem [ctqs_pkg::QUEUE_DEPTH];

    logic [TW-1:0]    outstanding;
    logic [TW:0]      phase_inc;
    logic             period_hit;
    logic             minute_sat;
    logic [TW-1:0]    minute_inc;
    logic             serve_due;
    logic [TW-1:0]    cancel_off;
    logic             cancel_in;
    logic             full;
    logic             advance_head;
    logic [SW-1:0]    head_slot_inc;
    logic             wr_en;
    logic [SW-1:0]    wr_addr;
    logic             wr_data;

    // slot of the ticket at a given offset from the head, offset below depth
    function automatic logic [SW-1:0] slot_at(input logic [SW-1:0] base,
                                              input logic [SW-1:0] off);
        logic [SW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[SW-1:0];
    endfunction

    assign outstanding = tail_reg - head_reg;
    assign phase_inc   = {1'b0, phase_reg} + {{TW{1'b0}}, 1'b1};
    assign period_hit  = phase_inc >= {1'b0, period_reg};
    assign minute_sat  = minute_reg == ctqs_pkg::MINUTE_MAX;
    assign minute_inc  = minute_reg + {{(TW-1){1'b0}}, 1'b1};
    assign serve_due   = !minute_sat && period_hit && (minute_inc <= close_reg);
    assign cancel_off  = item_cancel_reg - head_reg;
    assign cancel_in   = cancel_off < outstanding;
    assign full        = outstanding >= DEPTH_T;
    assign advance_head = cmd.advance || cmd.serve;
    assign head_slot_inc = ({1'b0, head_slot_reg} + {{SW{1'b0}}, 1'b1} == DEPTH_S)
                         ? '0 : head_slot_reg + {{(SW-1){1'b0}}, 1'b1};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = head_slot_reg;
        wr_data = 1'b0;
        if (cmd.exec_op)
        begin
            if (item_op_reg == ctqs_pkg::OP_ENTER && !full)
            begin
                wr_en   = 1'b1;
                wr_addr = slot_at(head_slot_reg, outstanding[SW-1:0]);
                wr_data = 1'b1;
            end
            else if (item_op_reg == ctqs_pkg::OP_CANCEL && cancel_in)
            begin
                wr_en   = 1'b1;
                wr_addr = slot_at(head_slot_reg, cancel_off[SW-1:0]);
            end
        end
        else if (cmd.serve)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            valid_mem[wr_addr] <= wr_data;
        end
        rd_valid_reg <= valid_mem[head_slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= ctqs_pkg::SERVICE_PERIOD_RST;
            close_reg     <= ctqs_pkg::CLOSE_TIME_RST;
            minute_reg    <= '0;
            phase_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            head_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ctqs_pkg::CFG_SERVICE_PERIOD: period_reg <= cfg_wdata;
                    ctqs_pkg::CFG_CLOSE_TIME:     close_reg  <= cfg_wdata;
                    default:                      ;
                endcase
            end
            if (cmd.exec_op)
            begin
                if (item_op_reg == ctqs_pkg::OP_TICK && !minute_sat)
                begin
                    minute_reg <= minute_inc;
                    phase_reg  <= period_hit ? '0 : phase_inc[TW-1:0];
                end
                if (item_op_reg == ctqs_pkg::OP_ENTER && !full)
                begin
                    tail_reg <= tail_reg + {{(TW-1){1'b0}}, 1'b1};
                end
            end
            if (advance_head)
            begin
                head_reg      <= head_reg + {{(TW-1){1'b0}}, 1'b1};
                head_slot_reg <= head_slot_inc;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg     <= ctqs_pkg::op_t'(op);
            item_cancel_reg <= cancel_ticket;
        end
        if (cmd.exec_op)
        begin
            res_served_valid_reg  <= 1'b0;
            res_served_ticket_reg <= '0;
            res_issued_reg        <= '0;
            res_status_reg        <= ctqs_pkg::ST_OK;
            case (item_op_reg)
                ctqs_pkg::OP_ENTER:
                begin
                    if (full)
                    begin
                        res_status_reg <= ctqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_issued_reg <= tail_reg;
                    end
                end
                ctqs_pkg::OP_CANCEL:
                begin
                    if (!cancel_in)
                    begin
                        res_status_reg <= ctqs_pkg::ST_RANGE;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.serve)
        begin
            res_served_valid_reg  <= 1'b1;
            res_served_ticket_reg <= head_reg;
        end
        if (cmd.emit)
        begin
            out_served_valid_reg  <= res_served_valid_reg;
            out_served_ticket_reg <= res_served_ticket_reg;
            out_issued_reg        <= res_issued_reg;
            out_status_reg        <= res_status_reg;
        end
    end

    assign stat.op          = item_op_reg;
    assign stat.serve_due   = serve_due;
    assign stat.queue_empty = outstanding == '0;
    assign stat.head_valid  = rd_valid_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign served_valid  = out_served_valid_reg;
    assign served_ticket = out_served_ticket_reg;
    assign issued_ticket = out_issued_reg;
    assign status        = out_status_reg;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the cancellable ticket queue server unit
module tb;
    import ctqs_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic                served;
        logic [TICKET_W-1:0] served_tkt;
        logic [TICKET_W-1:0] issued_tkt;
        logic [1:0]          stat;
    } queue_result_t;

    class ticket_scoreboard;
        bit                  slot_live[QUEUE_DEPTH];
        logic [TICKET_W-1:0] head_tkt;
        logic [TICKET_W-1:0] tail_tkt;
        logic [TICKET_W-1:0] minute;
        logic [TICKET_W-1:0] phase;
        logic [TICKET_W-1:0] period;
        logic [TICKET_W-1:0] close_minute;
        logic [SLOT_W-1:0]   head_slot;
        queue_result_t       awaited[$];
        int                  errors;
        int                  items;
        int                  served_count;
        int                  refused_count;
        int                  stray_cancels;
        bit                  head_wrapped;

        function new();
            foreach (slot_live[i])
                slot_live[i] = 1'b0;
            head_tkt      = '0;
            tail_tkt      = '0;
            minute        = '0;
            phase         = '0;
            period        = SERVICE_PERIOD_RST;
            close_minute  = CLOSE_TIME_RST;
            head_slot     = '0;
            errors        = 0;
            items         = 0;
            served_count  = 0;
            refused_count = 0;
            stray_cancels = 0;
            head_wrapped  = 1'b0;
        endfunction

        function int unsigned in_queue();
            logic [TICKET_W-1:0] gap;
            gap = tail_tkt - head_tkt;
            return gap;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICKET_W-1:0] value);
            if (idx == CFG_SERVICE_PERIOD)
                period = value;
            else
                close_minute = value;
        endfunction

        function void pop_head();
            head_tkt = head_tkt + 1'b1;
            if (head_tkt == '0)
                head_wrapped = 1'b1;
            head_slot = SLOT_W'((head_slot + 1) % QUEUE_DEPTH);
        endfunction

        function void note_item(op_t kind, logic [TICKET_W-1:0] tkt);
            queue_result_t       r;
            int unsigned         next_phase;
            bit                  due;
            logic [TICKET_W-1:0] gap;
            r = '0;
            case (kind)
                OP_TICK:
                begin
                    // the count sticks at its ceiling and such a tick does nothing
                    if (minute != MINUTE_MAX)
                    begin
                        next_phase = phase + 1;
                        minute     = minute + 1'b1;
                        due        = (next_phase >= period);
                        if (due)
                            next_phase = 0;
                        phase = next_phase;
                        if (due && minute <= close_minute)
                        begin
                            // lazy removal: cancelled tickets at the head are dropped now
                            while (in_queue() != 0 && !slot_live[head_slot])
                                pop_head();
                            if (in_queue() != 0)
                            begin
                                r.served             = 1'b1;
                                r.served_tkt         = head_tkt;
                                slot_live[head_slot] = 1'b0;
                                pop_head();
                                served_count++;
                            end
                        end
                    end
                end
                OP_ENTER:
                begin
                    if (in_queue() >= QUEUE_DEPTH)
                    begin
                        r.stat = ST_FULL;
                        refused_count++;
                    end
                    else
                    begin
                        slot_live[SLOT_W'((head_slot + in_queue()) % QUEUE_DEPTH)] = 1'b1;
                        r.issued_tkt = tail_tkt;
                        tail_tkt     = tail_tkt + 1'b1;
                    end
                end
                OP_CANCEL:
                begin
                    gap = tkt - head_tkt;
                    if (gap < in_queue())
                        slot_live[SLOT_W'((head_slot + gap) % QUEUE_DEPTH)] = 1'b0;
                    else
                    begin
                        r.stat = ST_RANGE;
                        stray_cancels++;
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
            items++;
        endfunction

        function void compare_field(string field, logic [TICKET_W-1:0] want,
                                    logic [TICKET_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d/%0d",
                             $time, got.served, got.served_tkt, got.issued_tkt, got.stat);
                return;
            end
            want = awaited.pop_front();
            compare_field("served_valid", want.served, got.served);
            compare_field("served_ticket", want.served_tkt, got.served_tkt);
            compare_field("issued_ticket", want.issued_tkt, got.issued_tkt);
            compare_field("status", want.stat, got.stat);
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [TICKET_W-1:0]  cfg_wdata     = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           op            = '0;
    logic [TICKET_W-1:0]  cancel_ticket = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic                 served_valid;
    logic [TICKET_W-1:0]  served_ticket;
    logic [TICKET_W-1:0]  issued_ticket;
    logic [1:0]           status;

    ticket_scoreboard sb;
    int               send_idle_pct = 20;
    int               recv_idle_pct = 85;
    bit               hold_request  = 1'b0;
    int               hold_left     = 0;
    int               quiet_cycles  = 0;

    cancellable_ticket_queue_server_unit DUT (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({served_valid, served_ticket, issued_ticket, status});
        if (hold_left == 0 && hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(op_t kind, logic [TICKET_W-1:0] tkt);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= kind;
        cancel_ticket <= tkt;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(kind, tkt);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(logic [TICKET_W-1:0] period, logic [TICKET_W-1:0] close_at);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SERVICE_PERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_index <= CFG_CLOSE_TIME;
        cfg_wdata <= close_at;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(CFG_SERVICE_PERIOD, period);
        sb.write_reg(CFG_CLOSE_TIME, close_at);
    endtask

    task automatic random_phase(int count, int enter_pct);
        int                  done;
        int                  pick;
        int unsigned         span;
        op_t                 kind;
        logic [TICKET_W-1:0] tkt;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            tkt  = TICKET_W'($urandom_range(16'hFFFF));
            if (pick < 3)
                kind = OP_NONE;
            else if (pick < 3 + enter_pct)
                kind = OP_ENTER;
            else if (pick < 3 + enter_pct + (97 - enter_pct) / 2)
                kind = OP_TICK;
            else
            begin
                kind = OP_CANCEL;
                span = sb.in_queue();
                // mostly live tickets, plus the edges of the window and strays
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5:
                        tkt = TICKET_W'(sb.head_tkt +
                                        ((span == 0) ? 0 : $urandom_range(span - 1)));
                    6: tkt = sb.tail_tkt;
                    7: tkt = sb.head_tkt - 1'b1;
                    8: tkt = TICKET_W'(sb.tail_tkt + $urandom_range(1, 200));
                    default: ;
                endcase
            end
            send_item(kind, tkt);
            if (kind != OP_NONE)
                done++;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_ENTER, 16'hFFFF);      // issued at minute zero
        send_item(OP_TICK, '0);
        send_item(OP_CANCEL, 16'd5);        // past the tail
        send_item(OP_CANCEL, 16'hFFFF);     // just behind the head
        send_item(OP_NONE, 16'hA5A5);
        send_item(OP_ENTER, '0);
        send_item(OP_CANCEL, 16'd0);
        send_item(OP_CANCEL, 16'd0);        // already cleared
        repeat (3) send_item(OP_TICK, '0);
        // period drops below the minutes already counted, so the next tick is due
        set_config(16'd2, CLOSE_TIME_RST);
        send_item(OP_TICK, '0);
        set_config(16'd1, sb.minute + 1'b1);
        send_item(OP_ENTER, '0);
        send_item(OP_TICK, '0);             // served on the closing minute
        send_item(OP_ENTER, '0);
        send_item(OP_TICK, '0);             // past closing
        send_item(OP_CANCEL, sb.tail_tkt - 1'b1);
        send_item(OP_ENTER, '0);

        set_config(16'd1, CLOSE_TIME_RST);
        random_phase(90, 35);
        set_config(16'hFFFF, CLOSE_TIME_RST);
        hold_request = 1'b1;                // long receiver stall while items keep coming
        random_phase(100, 75);

        send_idle_pct = 85;
        recv_idle_pct = 20;
        set_config(16'd0, CLOSE_TIME_RST);
        random_phase(90, 30);
        set_config(16'd3, sb.minute + 16'd15);
        random_phase(90, 35);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(TICKET_W'($urandom_range(1, 7)), 16'd0);
        random_phase(60, 40);
        set_config(16'd2, CLOSE_TIME_RST);
        random_phase(60, 35);
        drain_results();
        random_phase(60, 35);

        drain_results();
        repeat (20) @(posedge clk);
        $display("%0d items checked: %0d tickets served, %0d enters refused, %0d stray cancels",
                 sb.items, sb.errors == 0 ? sb.served_count : sb.served_count,
                 sb.refused_count, sb.stray_cancels);
        $display("ticket numbers wrapped: %0d, final minute %0d, mismatches %0d",
                 sb.head_wrapped, sb.minute, sb.errors);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ctqs_pkg.sv
hw/rtl/ctqs_ctrl.sv
hw/rtl/ctqs_datapath.sv
hw/rtl/cancellable_ticket_queue_server_unit.sv
verif/tb.sv
